### rtl/core/cbpe_pkg.sv
// Shared definitions for the cubic Bezier point evaluator.
// Holds default widths and configuration register codes; no dependencies.
`default_nettype none

package cbpe_pkg;

    // Default coordinate and parameter widths.
    localparam int unsigned COORD_BITS_DEF = 12;
    localparam int unsigned PARAM_BITS_DEF = 16;

    // Configuration register file geometry.
    localparam int unsigned NUM_CTRL     = 8;
    localparam int unsigned CFG_IDX_BITS = 3;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_CTRL_X0 = 3'd0,
        REG_CTRL_Y0 = 3'd1,
        REG_CTRL_X1 = 3'd2,
        REG_CTRL_Y1 = 3'd3,
        REG_CTRL_X2 = 3'd4,
        REG_CTRL_Y2 = 3'd5,
        REG_CTRL_X3 = 3'd6,
        REG_CTRL_Y3 = 3'd7
    } t_cfg_reg;

    // Pipeline depth of each section.
    localparam int unsigned WGEN_STAGES  = 4;
    localparam int unsigned BLEND_STAGES = 5;

endpackage : cbpe_pkg

`default_nettype wire

### rtl/core/cbpe_weight_gen.sv
// Bernstein weight generator: four pipeline stages turn t into the four
// exact integer weights. Depends on cbpe_pkg.
`default_nettype none

module cbpe_weight_gen #(
    parameter int unsigned PARAM_BITS = cbpe_pkg::PARAM_BITS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_ready,
    input  logic [PARAM_BITS-1:0]                   i_param,
    output logic                                    o_valid,
    input  logic                                    i_ready,
    output logic [3:0][3*PARAM_BITS:0]              o_weight
);
    import cbpe_pkg::*;

    localparam int unsigned P    = PARAM_BITS;
    localparam int unsigned SW   = P + 1;        // width of s = 2^P - p
    localparam int unsigned SQW  = 2 * P + 1;    // width of s^2 and p^2
    localparam int unsigned TW   = P + 2;        // width of 3s and 3p
    localparam int unsigned HW   = SQW - P;      // upper slice of a square
    localparam int unsigned LOW  = P + TW;       // low partial product
    localparam int unsigned PPW  = HW + TW;      // high partial product
    localparam int unsigned DW   = PPW + P;      // recombined product
    localparam int unsigned WW   = 3 * P + 1;    // weight width
    localparam int unsigned NSTG = WGEN_STAGES;

    localparam logic [SW-1:0] T_ONE = {1'b1, {P{1'b0}}};

    // Stage valid bits and advance enables.
    logic [NSTG-1:0] r_v;
    logic [NSTG-1:0] w_en;

    always_comb begin
        w_en[3] = !r_v[3] || i_ready;
        w_en[2] = !r_v[2] || w_en[3];
        w_en[1] = !r_v[1] || w_en[2];
        w_en[0] = !r_v[0] || w_en[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) r_v[0] <= i_valid;
            if (w_en[1]) r_v[1] <= r_v[0];
            if (w_en[2]) r_v[2] <= r_v[1];
            if (w_en[3]) r_v[3] <= r_v[2];
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_v[NSTG-1];

    // Stage A: register t and its complement s.
    logic [P-1:0]  r_a_p;
    logic [SW-1:0] r_a_s;

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_a_p <= i_param;
            r_a_s <= T_ONE - {1'b0, i_param};
        end
    end

    // Stage B: squares and the tripled multiplicands.
    logic [2*SW-1:0] w_ss;
    logic [2*P-1:0]  w_pp;
    logic [TW-1:0]   w_s3;
    logic [TW-1:0]   w_p3;
    logic [SQW-1:0]  r_b_ss;
    logic [SQW-1:0]  r_b_pp;
    logic [TW-1:0]   r_b_s;
    logic [TW-1:0]   r_b_p;
    logic [TW-1:0]   r_b_s3;
    logic [TW-1:0]   r_b_p3;

    assign w_ss = r_a_s * r_a_s;
    assign w_pp = r_a_p * r_a_p;
    assign w_s3 = {1'b0, r_a_s} + {r_a_s, 1'b0};
    assign w_p3 = {2'b00, r_a_p} + {1'b0, r_a_p, 1'b0};

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_b_ss <= w_ss[SQW-1:0];
            r_b_pp <= {1'b0, w_pp};
            r_b_s  <= {1'b0, r_a_s};
            r_b_p  <= {2'b00, r_a_p};
            r_b_s3 <= w_s3;
            r_b_p3 <= w_p3;
        end
    end

    // Stage C: square times multiplicand, split into two partial products.
    logic [3:0][SQW-1:0] w_big;
    logic [3:0][TW-1:0]  w_small;
    logic [3:0][LOW-1:0] w_lo;
    logic [3:0][PPW-1:0] w_hi;
    logic [3:0][LOW-1:0] r_c_lo;
    logic [3:0][PPW-1:0] r_c_hi;

    always_comb begin
        // (1-t)^3, 3t(1-t)^2, 3t^2(1-t), t^3 as square times factor.
        w_big[0]   = r_b_ss;
        w_small[0] = r_b_s;
        w_big[1]   = r_b_ss;
        w_small[1] = r_b_p3;
        w_big[2]   = r_b_pp;
        w_small[2] = r_b_s3;
        w_big[3]   = r_b_pp;
        w_small[3] = r_b_p;
        for (int i = 0; i < 4; i++) begin
            w_lo[i] = w_big[i][P-1:0] * w_small[i];
            w_hi[i] = w_big[i][SQW-1:P] * w_small[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r_c_lo <= w_lo;
            r_c_hi <= w_hi;
        end
    end

    // Stage D: recombine the partial products into the weights.
    logic [3:0][DW-1:0] w_full;
    logic [3:0][WW-1:0] r_d_w;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_full[i] = {r_c_hi[i], {P{1'b0}}} + DW'(r_c_lo[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            for (int i = 0; i < 4; i++) begin
                r_d_w[i] <= w_full[i][WW-1:0];
            end
        end
    end

    assign o_weight = r_d_w;

endmodule : cbpe_weight_gen

`default_nettype wire

### rtl/core/cbpe_blend.sv
// Weighted coordinate blend: five pipeline stages multiply, sum and
// truncate the curve point for both axes. Depends on cbpe_pkg.
`default_nettype none

module cbpe_blend #(
    parameter int unsigned COORD_BITS = cbpe_pkg::COORD_BITS_DEF,
    parameter int unsigned PARAM_BITS = cbpe_pkg::PARAM_BITS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_ready,
    input  logic [3:0][3*PARAM_BITS:0]              i_weight,
    input  logic [3:0][COORD_BITS-1:0]              i_coord_x,
    input  logic [3:0][COORD_BITS-1:0]              i_coord_y,
    output logic                                    o_valid,
    input  logic                                    i_ready,
    output logic signed [COORD_BITS-1:0]            o_point_x,
    output logic signed [COORD_BITS-1:0]            o_point_y
);
    import cbpe_pkg::*;

    localparam int unsigned C    = COORD_BITS;
    localparam int unsigned FR   = 3 * PARAM_BITS;  // fraction bits of the sum
    localparam int unsigned WW   = FR + 1;
    localparam int unsigned WL   = (WW + 1) / 2;
    localparam int unsigned WH   = WW - WL;
    localparam int unsigned PW   = WW + C;
    localparam int unsigned SUMW = FR + C;
    localparam int unsigned NSTG = BLEND_STAGES;

    // Stage valid bits and advance enables.
    logic [NSTG-1:0] r_v;
    logic [NSTG-1:0] w_en;

    always_comb begin
        w_en[4] = !r_v[4] || i_ready;
        w_en[3] = !r_v[3] || w_en[4];
        w_en[2] = !r_v[2] || w_en[3];
        w_en[1] = !r_v[1] || w_en[2];
        w_en[0] = !r_v[0] || w_en[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) r_v[0] <= i_valid;
            if (w_en[1]) r_v[1] <= r_v[0];
            if (w_en[2]) r_v[2] <= r_v[1];
            if (w_en[3]) r_v[3] <= r_v[2];
            if (w_en[4]) r_v[4] <= r_v[3];
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_v[NSTG-1];

    // Stage E: weight halves times biased coordinates.
    logic [1:0][3:0][C-1:0]    w_coord;
    logic [1:0][3:0][WL+C-1:0] w_lo;
    logic [1:0][3:0][WH+C-1:0] w_hi;
    logic [1:0][3:0][WL+C-1:0] r_e_lo;
    logic [1:0][3:0][WH+C-1:0] r_e_hi;

    always_comb begin
        w_coord[0] = i_coord_x;
        w_coord[1] = i_coord_y;
        for (int a = 0; a < 2; a++) begin
            for (int i = 0; i < 4; i++) begin
                w_lo[a][i] = i_weight[i][WL-1:0] * w_coord[a][i];
                w_hi[a][i] = i_weight[i][WW-1:WL] * w_coord[a][i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_e_lo <= w_lo;
            r_e_hi <= w_hi;
        end
    end

    // Stage F: recombine each weighted coordinate.
    logic [1:0][3:0][PW-1:0] w_prod;
    logic [1:0][3:0][PW-1:0] r_f_prod;

    always_comb begin
        for (int a = 0; a < 2; a++) begin
            for (int i = 0; i < 4; i++) begin
                w_prod[a][i] = {r_e_hi[a][i], {WL{1'b0}}} + PW'(r_e_lo[a][i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_f_prod <= w_prod;
        end
    end

    // Stage G: first level of the sum tree.
    logic [1:0][PW-1:0] r_g_s01;
    logic [1:0][PW-1:0] r_g_s23;

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            for (int a = 0; a < 2; a++) begin
                r_g_s01[a] <= r_f_prod[a][0] + r_f_prod[a][1];
                r_g_s23[a] <= r_f_prod[a][2] + r_f_prod[a][3];
            end
        end
    end

    // Stage H: full weighted sum; it is below 2^SUMW by convexity.
    logic [1:0][PW-1:0]   w_tot;
    logic [1:0][SUMW-1:0] r_h_sum;

    always_comb begin
        for (int a = 0; a < 2; a++) begin
            w_tot[a] = r_g_s01[a] + r_g_s23[a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            for (int a = 0; a < 2; a++) begin
                r_h_sum[a] <= w_tot[a][SUMW-1:0];
            end
        end
    end

    // Stage I: remove the bias and truncate toward zero.  A clear top bit
    // of the integer part means a negative point, which rounds up when
    // any fraction bit is set.
    logic [1:0][C-1:0] w_q;
    logic [1:0]        w_up;
    logic [1:0][C-1:0] w_pt;
    logic [1:0][C-1:0] r_i_pt;

    always_comb begin
        for (int a = 0; a < 2; a++) begin
            w_q[a]  = r_h_sum[a][SUMW-1:FR];
            w_up[a] = !w_q[a][C-1] && (|r_h_sum[a][FR-1:0]);
            w_pt[a] = {~w_q[a][C-1], w_q[a][C-2:0]} + C'(w_up[a]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r_i_pt <= w_pt;
        end
    end

    assign o_point_x = signed'(r_i_pt[0]);
    assign o_point_y = signed'(r_i_pt[1]);

endmodule : cbpe_blend

`default_nettype wire

### rtl/core/cubic_bezier_point_evaluator_unit.sv
// Top level of the cubic Bezier point evaluator: control point registers,
// weight generator and blend pipeline. Depends on cbpe_pkg, cbpe_weight_gen
// and cbpe_blend.
//
//   Channel   Dir  Handshake                 Contents
//   s stream  in   i_s_tvalid / o_s_tready   param_t
//   m stream  out  o_m_tvalid / i_m_tready   point_x, point_y
//   cfg       in   i_cfg_we                  control point registers
//
// One item is accepted per clock unless a stalled output has filled every stage.
// Each item passes nine register stages (four weight stages, five blend stages)
// before its result is offered on the m stream.
// Reset clears the stage valid bits and the control points.
// A stalled output holds the full stages in place, while empty stages
// ahead of it keep taking items, so nothing is lost or repeated.
`default_nettype none

module cubic_bezier_point_evaluator_unit #(
    parameter int unsigned COORD_BITS = cbpe_pkg::COORD_BITS_DEF,
    parameter int unsigned PARAM_BITS = cbpe_pkg::PARAM_BITS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // Input stream.
    input  logic                                    i_s_tvalid,
    output logic                                    o_s_tready,
    // tdata: param_t, zero padded to whole bytes.
    input  logic [((PARAM_BITS+7)/8)*8-1:0]         i_s_tdata,
    // Output stream.
    output logic                                    o_m_tvalid,
    input  logic                                    i_m_tready,
    // tdata: point_x, then point_y, zero padded to whole bytes.
    output logic [((2*COORD_BITS+7)/8)*8-1:0]       o_m_tdata,
    // Configuration write port.
    input  logic                                    i_cfg_we,
    input  logic [cbpe_pkg::CFG_IDX_BITS-1:0]       i_cfg_index,
    input  logic [COORD_BITS-1:0]                   i_cfg_data
);
    import cbpe_pkg::*;

    localparam int unsigned C     = COORD_BITS;
    localparam int unsigned WW    = 3 * PARAM_BITS + 1;
    localparam int unsigned OUT_W = ((2 * COORD_BITS + 7) / 8) * 8;

    localparam logic [C-1:0] T_BIAS = {1'b1, {(C-1){1'b0}}};

    // Control point registers.
    logic [NUM_CTRL-1:0][C-1:0] r_ctrl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '0;
        end else if (i_cfg_we) begin
            r_ctrl[i_cfg_index] <= i_cfg_data;
        end
    end

    // Offset-binary coordinates keep every product unsigned.
    logic [3:0][C-1:0] w_cx;
    logic [3:0][C-1:0] w_cy;

    always_comb begin
        w_cx[0] = r_ctrl[REG_CTRL_X0] ^ T_BIAS;
        w_cx[1] = r_ctrl[REG_CTRL_X1] ^ T_BIAS;
        w_cx[2] = r_ctrl[REG_CTRL_X2] ^ T_BIAS;
        w_cx[3] = r_ctrl[REG_CTRL_X3] ^ T_BIAS;
        w_cy[0] = r_ctrl[REG_CTRL_Y0] ^ T_BIAS;
        w_cy[1] = r_ctrl[REG_CTRL_Y1] ^ T_BIAS;
        w_cy[2] = r_ctrl[REG_CTRL_Y2] ^ T_BIAS;
        w_cy[3] = r_ctrl[REG_CTRL_Y3] ^ T_BIAS;
    end

    // Weight generator.
    logic                 w_wg_valid;
    logic                 w_bl_ready;
    logic [3:0][WW-1:0]   w_weight;

    cbpe_weight_gen #(
        .PARAM_BITS (PARAM_BITS)
    ) u_wgen (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .o_ready  (o_s_tready),
        .i_param  (i_s_tdata[PARAM_BITS-1:0]),
        .o_valid  (w_wg_valid),
        .i_ready  (w_bl_ready),
        .o_weight (w_weight)
    );

    // Blend pipeline; its last stage is the output register.
    logic signed [C-1:0] w_px;
    logic signed [C-1:0] w_py;

    cbpe_blend #(
        .COORD_BITS (COORD_BITS),
        .PARAM_BITS (PARAM_BITS)
    ) u_blend (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_wg_valid),
        .o_ready   (w_bl_ready),
        .i_weight  (w_weight),
        .i_coord_x (w_cx),
        .i_coord_y (w_cy),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_point_x (w_px),
        .o_point_y (w_py)
    );

    assign o_m_tdata = OUT_W'({w_py, w_px});

    // Checks.
    logic w_s_acc;
    logic w_run;

    assign w_s_acc = i_s_tvalid && o_s_tready && i_rst_n;
    assign w_run   = i_m_tready && i_rst_n;

    // An empty output stage lets every stage advance, so input is open.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input blocked while the output stage is empty");

    // Without back-pressure an accepted item reaches the output register.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(w_s_acc, 9) && $past(w_run, 1) && $past(w_run, 2) &&
         $past(w_run, 3) && $past(w_run, 4) && $past(w_run, 5) &&
         $past(w_run, 6) && $past(w_run, 7) && $past(w_run, 8))
        |-> o_m_tvalid)
        else $error("item missing at the output after the pipeline latency");

endmodule : cubic_bezier_point_evaluator_unit

`default_nettype wire

### verif/cbpe_checker.sv
// Checker for the cubic Bezier point evaluator: watches the config port and both streams,
// predicts each curve point and compares it with what the block returns.
// Depends on cbpe_pkg for the register codes.
`timescale 1ns / 1ps

module cbpe_checker #(
    parameter int unsigned COORD_BITS = cbpe_pkg::COORD_BITS_DEF,
    parameter int unsigned PARAM_BITS = cbpe_pkg::PARAM_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    input  logic                                i_s_tready,
    // tdata: param_t.
    input  logic [((PARAM_BITS+7)/8)*8-1:0]     i_s_tdata,
    input  logic                                i_m_tvalid,
    input  logic                                i_m_tready,
    // tdata: point_x, then point_y.
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]   i_m_tdata,
    input  logic                                i_cfg_we,
    input  logic [cbpe_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [COORD_BITS-1:0]               i_cfg_data,
    output int                                  o_fail_count,
    output int                                  o_pending
);
    import cbpe_pkg::*;

    localparam int unsigned SHIFT_ALL = 3 * PARAM_BITS;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
    } t_point;

    logic [COORD_BITS-1:0] ctrl_shadow [NUM_CTRL];
    t_point                pending_points [$];

    // Exact weighted sum of four coordinates, divided by 2^(3*PARAM_BITS) toward zero.
    // Coordinates are offset by half their range so the sum stays non-negative.
    function automatic logic [COORD_BITS-1:0] blend_coord(
        input logic [127:0]          w0,
        input logic [127:0]          w1,
        input logic [127:0]          w2,
        input logic [127:0]          w3,
        input logic [COORD_BITS-1:0] c0,
        input logic [COORD_BITS-1:0] c1,
        input logic [COORD_BITS-1:0] c2,
        input logic [COORD_BITS-1:0] c3
    );
        logic [COORD_BITS-1:0] bias_bits;
        logic [127:0]          acc;
        logic [127:0]          quot;
        logic [127:0]          frac;
        logic signed [127:0]   whole;
        bias_bits = '0;
        bias_bits[COORD_BITS-1] = 1'b1;
        acc = w0 * 128'(c0 ^ bias_bits) + w1 * 128'(c1 ^ bias_bits)
            + w2 * 128'(c2 ^ bias_bits) + w3 * 128'(c3 ^ bias_bits);
        quot  = acc >> SHIFT_ALL;
        frac  = acc & ((128'd1 << SHIFT_ALL) - 128'd1);
        whole = $signed(quot) - $signed(128'(bias_bits));
        // A negative sum with a fraction left over rounds up, toward zero.
        if (whole < 0 && frac != 0) begin
            whole = whole + 1;
        end
        return whole[COORD_BITS-1:0];
    endfunction

    // Bernstein weights from t and s = 1 - t, both scaled by 2^PARAM_BITS.
    function automatic t_point predict_point(input logic [PARAM_BITS-1:0] t_val);
        logic [127:0] tw;
        logic [127:0] sw;
        logic [127:0] w0;
        logic [127:0] w1;
        logic [127:0] w2;
        logic [127:0] w3;
        t_point       pt;
        tw = 128'(t_val);
        sw = (128'd1 << PARAM_BITS) - tw;
        w0 = sw * sw * sw;
        w1 = 128'd3 * tw * sw * sw;
        w2 = 128'd3 * tw * tw * sw;
        w3 = tw * tw * tw;
        pt.x = blend_coord(w0, w1, w2, w3, ctrl_shadow[REG_CTRL_X0], ctrl_shadow[REG_CTRL_X1],
                           ctrl_shadow[REG_CTRL_X2], ctrl_shadow[REG_CTRL_X3]);
        pt.y = blend_coord(w0, w1, w2, w3, ctrl_shadow[REG_CTRL_Y0], ctrl_shadow[REG_CTRL_Y1],
                           ctrl_shadow[REG_CTRL_Y2], ctrl_shadow[REG_CTRL_Y3]);
        return pt;
    endfunction

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Track the control points, queue a prediction per accepted item, check each result.
    always @(posedge i_clk) begin
        t_point want;
        t_point got;
        if (!i_rst_n) begin
            foreach (ctrl_shadow[i]) ctrl_shadow[i] = '0;
            pending_points.delete();
        end else begin
            if (i_cfg_we) begin
                ctrl_shadow[i_cfg_index] = i_cfg_data;
            end
            if (i_s_tvalid && i_s_tready) begin
                pending_points.push_back(predict_point(i_s_tdata[PARAM_BITS-1:0]));
            end
            if (i_m_tvalid && i_m_tready) begin
                got.x = i_m_tdata[COORD_BITS-1:0];
                got.y = i_m_tdata[2*COORD_BITS-1:COORD_BITS];
                if (pending_points.size() == 0) begin
                    $error("unexpected result: point_x %0d, point_y %0d", got.x, got.y);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = pending_points.pop_front();
                    if (got.x !== want.x) begin
                        $error("point_x mismatch: expected %0d, actual %0d", want.x, got.x);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (got.y !== want.y) begin
                        $error("point_y mismatch: expected %0d, actual %0d", want.y, got.y);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
        end
        o_pending = pending_points.size();
    end

endmodule : cbpe_checker

### verif/tb_top.sv
// Testbench top for the cubic Bezier point evaluator: clock, reset, control point loads,
// directed and random parameter streams with random back-pressure. Depends on cbpe_pkg,
// the evaluator RTL and cbpe_checker.
`timescale 1ns / 1ps

module tb_top;
    import cbpe_pkg::*;

    localparam int unsigned COORD_BITS   = COORD_BITS_DEF;
    localparam int unsigned PARAM_BITS   = PARAM_BITS_DEF;
    localparam int unsigned S_TDATA_W    = ((PARAM_BITS + 7) / 8) * 8;
    localparam int          PIPE_DEPTH   = WGEN_STAGES + BLEND_STAGES;
    localparam int          CYCLE_LIMIT  = 600000;
    localparam int          RAND_PHASES  = 14;
    localparam int          PHASE_ITEMS  = 125;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          COORD_MIN    = -(2 ** (COORD_BITS - 1));
    localparam int          COORD_MAX    = 2 ** (COORD_BITS - 1) - 1;
    localparam int          PARAM_MAX    = 2 ** PARAM_BITS - 1;

    logic                                 i_clk;
    logic                                 i_rst_n;
    logic                                 i_s_tvalid;
    logic                                 o_s_tready;
    logic [((PARAM_BITS+7)/8)*8-1:0]      i_s_tdata;
    logic                                 o_m_tvalid;
    logic                                 i_m_tready;
    logic [((2*COORD_BITS+7)/8)*8-1:0]    o_m_tdata;
    logic                                 i_cfg_we;
    logic [CFG_IDX_BITS-1:0]              i_cfg_index;
    logic [COORD_BITS-1:0]                i_cfg_data;

    int fail_count;
    int pending;
    int cycle_count;

    // Traffic shaping flags set by the main sequence for the sender and the receiver.
    bit tx_steady;
    bit rx_steady;
    bit rx_hold;

    logic [COORD_BITS-1:0] ctrl_plan [NUM_CTRL];

    cubic_bezier_point_evaluator_unit #(
        .COORD_BITS (COORD_BITS),
        .PARAM_BITS (PARAM_BITS)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    cbpe_checker #(
        .COORD_BITS (COORD_BITS),
        .PARAM_BITS (PARAM_BITS)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog on the whole run.
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // Idle length: mostly none or short, a few long.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 90);
    endfunction

    // Parameter values: mostly uniform, some crowded at either end of the curve.
    function automatic logic [PARAM_BITS-1:0] pick_param();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return PARAM_BITS'($urandom_range(0, 15));
        if (r == 1) return PARAM_BITS'($urandom_range(PARAM_MAX - 15, PARAM_MAX));
        return PARAM_BITS'($urandom_range(0, PARAM_MAX));
    endfunction

    // Coordinates: uniform, range extremes only, or values near zero.
    function automatic logic [COORD_BITS-1:0] pick_coord(input int mode);
        case (mode)
            1: begin
                return ($urandom_range(0, 1) == 1) ? COORD_BITS'(COORD_MAX)
                                                   : COORD_BITS'(COORD_MIN);
            end
            2: begin
                return COORD_BITS'($urandom_range(0, 4) - 2);
            end
            default: begin
                return COORD_BITS'($urandom);
            end
        endcase
    endfunction

    // Receiver: random ready pattern, steady ready, or one long hold-off on request.
    initial begin
        int n;
        i_m_tready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (rx_hold) begin
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                rx_hold = 1'b0;
            end else if (rx_steady) begin
                i_m_tready <= 1'b1;
                @(posedge i_clk);
            end else if ($urandom_range(0, 9) < 7) begin
                i_m_tready <= 1'b1;
                n = idle_len() + 1;
                repeat (n) @(posedge i_clk);
            end else begin
                i_m_tready <= 1'b0;
                n = idle_len() + 1;
                repeat (n) @(posedge i_clk);
            end
        end
    end

    // Offer one item, after an optional gap, and wait until it is taken.
    task automatic drive_param(input logic [PARAM_BITS-1:0] t_val);
        int gap;
        gap = tx_steady ? 0 : idle_len();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= S_TDATA_W'(t_val);
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    // Let every outstanding item come back before the control points change.
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 2) @(posedge i_clk);
    endtask

    // Write all eight control point registers from the plan, one per cycle.
    task automatic load_ctrl_plan();
        t_cfg_reg r;
        r = r.first();
        repeat (NUM_CTRL) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= r;
            i_cfg_data  <= ctrl_plan[r];
            @(posedge i_clk);
            r = r.next();
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_plan(input int x0, input int y0, input int x1, input int y1,
                            input int x2, input int y2, input int x3, input int y3);
        ctrl_plan[REG_CTRL_X0] = COORD_BITS'(x0);
        ctrl_plan[REG_CTRL_Y0] = COORD_BITS'(y0);
        ctrl_plan[REG_CTRL_X1] = COORD_BITS'(x1);
        ctrl_plan[REG_CTRL_Y1] = COORD_BITS'(y1);
        ctrl_plan[REG_CTRL_X2] = COORD_BITS'(x2);
        ctrl_plan[REG_CTRL_Y2] = COORD_BITS'(y2);
        ctrl_plan[REG_CTRL_X3] = COORD_BITS'(x3);
        ctrl_plan[REG_CTRL_Y3] = COORD_BITS'(y3);
        wait_drained();
        load_ctrl_plan();
    endtask

    // Main sequence: reset, directed curves, then random phases.
    initial begin
        int mode;
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = REG_CTRL_X0;
        i_cfg_data  = '0;
        tx_steady   = 1'b0;
        rx_steady   = 1'b0;
        rx_hold     = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Control points straight out of reset, all zero.
        drive_param('0);
        drive_param(PARAM_BITS'(PARAM_MAX));

        // Degenerate curve at the range extremes: x at the minimum, y at the maximum.
        set_plan(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX,
                 COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX);
        drive_param('0);
        drive_param(PARAM_BITS'(PARAM_MAX));
        drive_param(PARAM_BITS'(1 << (PARAM_BITS - 1)));

        // Zigzag between the extremes exercises the largest weighted sums.
        set_plan(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN,
                 COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN);
        drive_param('0);
        drive_param(PARAM_BITS'(1));
        drive_param(PARAM_BITS'(2));
        drive_param(PARAM_BITS'(1 << (PARAM_BITS - 1)));
        drive_param(PARAM_BITS'(PARAM_MAX - 1));
        drive_param(PARAM_BITS'(PARAM_MAX));
        drive_param(PARAM_BITS'(PARAM_MAX / 3));
        drive_param(PARAM_BITS'(2 * (PARAM_MAX / 3)));

        // Tiny fractional results: negative ones must truncate toward zero, not down.
        set_plan(-1, 1, 0, 0, 0, 0, 0, 0);
        drive_param('0);
        drive_param(PARAM_BITS'(1));
        drive_param(PARAM_BITS'(1 << (PARAM_BITS - 1)));
        drive_param(PARAM_BITS'(PARAM_MAX));

        // End point weight close to one but never reaching it.
        set_plan(0, 0, 0, 0, 0, 0, -1, COORD_MAX);
        drive_param(PARAM_BITS'(PARAM_MAX));
        drive_param(PARAM_BITS'(PARAM_MAX - 1));
        drive_param(PARAM_BITS'(1));

        // Random phases, each with its own control points and traffic shape.
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            mode = ph % 3;
            foreach (ctrl_plan[i]) ctrl_plan[i] = pick_coord(mode);
            wait_drained();
            load_ctrl_plan();
            tx_steady = (ph == 3) || (ph == 6) || (ph == 9);
            rx_steady = (ph == 3) || (ph == 9);
            // One phase stalls the output long enough to back up the input.
            if (ph == 6) begin
                rx_hold = 1'b1;
            end
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                drive_param(pick_param());
            end
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;

        wait_drained();
        repeat (PIPE_DEPTH * 2) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule : tb_top

### files.f
rtl/core/cbpe_pkg.sv
rtl/core/cbpe_weight_gen.sv
rtl/core/cbpe_blend.sv
rtl/core/cubic_bezier_point_evaluator_unit.sv
verif/cbpe_checker.sv
verif/tb_top.sv
